FILE: hw/rtl/lmlp_pkg.sv
`default_nettype none

package lmlp_pkg;

    localparam int IDLE_WIDTH   = 32;
    localparam int LED_W        = 8;
    localparam int LOAD_W       = 7;
    localparam int MODE_W       = 2;
    localparam int POLL_W       = 8;
    localparam int EXPECT_W     = 16;
    localparam int SCALE_W      = 4;
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int SWEEP_W      = 11;
    localparam int RAND_W       = 8;
    localparam int LFSR_W       = 16;
    localparam int POS_W        = 4;
    localparam int PRODUCT_W    = EXPECT_W + SCALE_W;

    localparam int LOAD_MAX     = 100;
    localparam int SWEEP_WRAP   = 1400;
    localparam int SWEEP_SLOT   = 100;
    localparam int SWEEP_SLOTS  = SWEEP_WRAP / SWEEP_SLOT;
    localparam int RANDOM_LIMIT = 100;
    localparam int CYLON_GAIN   = 97;
    localparam int CYLON_BASE   = 3;
    localparam int RANDOM_GAIN  = 96;
    localparam int RANDOM_BASE  = 4;
    localparam int LOAD_CODES   = 2 ** LOAD_W;

    localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
    localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'h0001;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL     = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE    = 8'd3;

    localparam logic [POLL_W-1:0]   POLL_RESET     = 8'd25;
    localparam logic [EXPECT_W-1:0] EXPECTED_RESET = 16'd50;
    localparam logic [SCALE_W-1:0]  SCALE_RESET    = 4'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_BARGRAPH = 2'd0,
        MODE_CYLON    = 2'd1,
        MODE_RANDOM   = 2'd2,
        MODE_OFF      = 2'd3
    } mode_t;

    typedef struct packed {
        logic              step;
        mode_t             mode;
        logic [LOAD_W-1:0] load;
    } gen_ctrl_t;

    typedef logic [LOAD_W-1:0] step_table_t [LOAD_CODES];
    typedef logic [LED_W-1:0]  led_table_t  [LOAD_CODES];
    typedef logic [LED_W-1:0]  fill_table_t [8];
    typedef logic [LED_W-1:0]  cylon_table_t [SWEEP_SLOTS];

    localparam fill_table_t FILL_TABLE = '{
        8'h00, 8'h80, 8'hC0, 8'hE0, 8'hF8, 8'hFC, 8'hFE, 8'hFF
    };

    // One lit LED bouncing left to right and back over fourteen positions.
    localparam cylon_table_t CYLON_LED = '{
        8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02,
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40
    };

    function automatic step_table_t build_step_table(input int gain, input int base);
        step_table_t t;
        for (int i = 0; i < LOAD_CODES; i++) begin
            t[i] = LOAD_W'(base + (i * gain) / 100);
        end
        return t;
    endfunction

    function automatic led_table_t build_bar_table();
        led_table_t t;
        int         idx;
        for (int i = 0; i < LOAD_CODES; i++) begin
            idx = i / 3;
            if (idx > 7) begin
                idx = 7;
            end
            t[i] = FILL_TABLE[idx];
        end
        return t;
    endfunction

    localparam step_table_t CYLON_STEP  = build_step_table(CYLON_GAIN, CYLON_BASE);
    localparam step_table_t RANDOM_STEP = build_step_table(RANDOM_GAIN, RANDOM_BASE);
    localparam led_table_t  BAR_LED     = build_bar_table();

endpackage

`default_nettype wire

FILE: hw/rtl/lmlp_pattern_gen.sv
`default_nettype none

module lmlp_pattern_gen
    import lmlp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire gen_ctrl_t        ctrl,
    output logic [LED_W-1:0]      led_bits
);

    logic [SWEEP_W-1:0] sweep_reg, sweep_next;
    logic [RAND_W-1:0]  rand_accum_reg, rand_accum_next;
    logic [LED_W-1:0]   rand_pattern_reg, rand_pattern_next;
    logic [LFSR_W-1:0]  lfsr_reg, lfsr_next;

    logic [SWEEP_W-1:0] sweep_sum;
    logic [RAND_W-1:0]  rand_sum;
    logic [LFSR_W-1:0]  lfsr_step;
    logic [POS_W-1:0]   pos;

    always_comb begin
        sweep_sum = sweep_reg + SWEEP_W'(CYLON_STEP[ctrl.load]);
        rand_sum  = rand_accum_reg + RAND_W'(RANDOM_STEP[ctrl.load]);
        lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);

        sweep_next        = sweep_reg;
        rand_accum_next   = rand_accum_reg;
        rand_pattern_next = rand_pattern_reg;
        lfsr_next         = lfsr_reg;

        if (ctrl.step && ctrl.mode == MODE_CYLON) begin
            sweep_next = (sweep_sum >= SWEEP_W'(SWEEP_WRAP)) ? '0 : sweep_sum;
        end

        if (ctrl.step && ctrl.mode == MODE_RANDOM) begin
            if (rand_sum > RAND_W'(RANDOM_LIMIT)) begin
                rand_accum_next   = '0;
                lfsr_next         = lfsr_step;
                rand_pattern_next = lfsr_step[LED_W-1:0];
            end else begin
                rand_accum_next = rand_sum;
            end
        end

        // Position is the sweep count in hundreds, found by parallel compares.
        pos = '0;
        for (int k = 1; k < SWEEP_SLOTS; k++) begin
            pos = pos + POS_W'(sweep_next >= SWEEP_W'(k * SWEEP_SLOT));
        end

        case (ctrl.mode)
            MODE_BARGRAPH: led_bits = BAR_LED[ctrl.load];
            MODE_CYLON:    led_bits = CYLON_LED[pos];
            MODE_RANDOM:   led_bits = rand_pattern_next;
            default:       led_bits = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg        <= '0;
            rand_accum_reg   <= '0;
            rand_pattern_reg <= '0;
            lfsr_reg         <= LFSR_SEED;
        end else begin
            sweep_reg        <= sweep_next;
            rand_accum_reg   <= rand_accum_next;
            rand_pattern_reg <= rand_pattern_next;
            lfsr_reg         <= lfsr_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/load_meter_led_pattern_unit.sv
// An accepted input word loads into the input register and passes on to the result
// register, where its result word is valid; a stall on m_ready holds it in between.
// Throughput: one word per cycle, less when m_ready stalls; the load update and
// the pattern step both settle in the single logic stage between the two registers.
// Reset (aresetn low, synchronous) clears the pipeline, restores the
// register defaults and returns the generators to their start state.
`default_nettype none

module load_meter_led_pattern_unit
    import lmlp_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [IDLE_WIDTH-1:0]  s_idle_count,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [LED_W-1:0]            m_led_bits,
    output logic [LOAD_W-1:0]           m_load_percent
);

    mode_t               mode_reg;
    logic [POLL_W-1:0]   poll_interval_reg;
    logic [EXPECT_W-1:0] expected_reg;
    logic [SCALE_W-1:0]  scale_reg;

    logic                  in_valid_reg;
    logic [IDLE_WIDTH-1:0] in_idle_reg;

    logic                  seeded_reg;
    logic [POLL_W-1:0]     poll_count_reg, poll_count_next;
    logic [IDLE_WIDTH-1:0] baseline_reg, baseline_next;
    logic [LOAD_W-1:0]     load_reg, load_next;

    logic                  m_valid_reg;
    logic [LED_W-1:0]      m_led_bits_reg;
    logic [LOAD_W-1:0]     m_load_percent_reg;

    logic                  advance;
    logic [IDLE_WIDTH-1:0] delta;
    logic [POLL_W:0]       poll_inc;
    logic [POLL_W-1:0]     poll_limit;
    logic [EXPECT_W-1:0]   shortfall;
    logic [PRODUCT_W-1:0]  product;
    logic [LOAD_W-1:0]     load_calc;
    gen_ctrl_t             gen_ctrl;
    logic [LED_W-1:0]      gen_leds;

    assign cfg_ready      = 1'b1;
    assign advance        = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready        = !in_valid_reg || advance;
    assign m_valid        = m_valid_reg;
    assign m_led_bits     = m_led_bits_reg;
    assign m_load_percent = m_load_percent_reg;

    always_comb begin
        delta      = in_idle_reg - baseline_reg;
        poll_inc   = {1'b0, poll_count_reg} + 1'b1;
        poll_limit = (poll_interval_reg == '0) ? POLL_W'(1) : poll_interval_reg;
        shortfall  = expected_reg - delta[EXPECT_W-1:0];
        product    = PRODUCT_W'(shortfall) * PRODUCT_W'(scale_reg);

        // A delta at or above the expected idle count means no load at all.
        if (delta >= IDLE_WIDTH'(expected_reg)) begin
            load_calc = '0;
        end else if (product > PRODUCT_W'(LOAD_MAX)) begin
            load_calc = LOAD_W'(LOAD_MAX);
        end else begin
            load_calc = product[LOAD_W-1:0];
        end

        poll_count_next = poll_count_reg;
        baseline_next   = baseline_reg;
        load_next       = load_reg;

        if (advance) begin
            if (!seeded_reg) begin
                baseline_next = in_idle_reg;
            end else if (poll_inc >= {1'b0, poll_limit}) begin
                poll_count_next = '0;
                baseline_next   = in_idle_reg;
                load_next       = load_calc;
            end else begin
                poll_count_next = poll_inc[POLL_W-1:0];
            end
        end

        gen_ctrl.step = advance && seeded_reg;
        gen_ctrl.mode = mode_reg;
        gen_ctrl.load = load_next;
    end

    lmlp_pattern_gen u_pattern_gen (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (gen_ctrl),
        .led_bits (gen_leds)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_CYLON;
            poll_interval_reg <= POLL_RESET;
            expected_reg      <= EXPECTED_RESET;
            scale_reg         <= SCALE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MODE:     mode_reg          <= mode_t'(cfg_data[MODE_W-1:0]);
                CFG_POLL:     poll_interval_reg <= cfg_data[POLL_W-1:0];
                CFG_EXPECTED: expected_reg      <= cfg_data[EXPECT_W-1:0];
                CFG_SCALE:    scale_reg         <= cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            seeded_reg     <= 1'b0;
            poll_count_reg <= '0;
            baseline_reg   <= '0;
            load_reg       <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                m_valid_reg <= 1'b1;
                seeded_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            poll_count_reg <= poll_count_next;
            baseline_reg   <= baseline_next;
            load_reg       <= load_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_idle_reg <= s_idle_count;
        end
        if (advance) begin
            // The seeding word shows dark LEDs and the load as it stood.
            m_led_bits_reg     <= seeded_reg ? gen_leds : '0;
            m_load_percent_reg <= load_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lmlp_checker.sv
`default_nettype none

module lmlp_checker
    import lmlp_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   cfg_valid,
    input wire logic                   cfg_ready,
    input wire logic [CFG_INDEX_W-1:0] cfg_index,
    input wire logic [CFG_DATA_W-1:0]  cfg_data,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire logic [LED_W-1:0]       m_led_bits,
    input wire logic [LOAD_W-1:0]      m_load_percent
);

    // Shadow of the mode register, followed from the configuration port.
    logic [MODE_W-1:0] mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_CYLON;
        end else if (cfg_valid && cfg_ready && cfg_index == CFG_MODE) begin
            mode_reg <= cfg_data[MODE_W-1:0];
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_led_bits) && $stable(m_load_percent))
        else $error("stalled result word changed");

    a_load_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_load_percent <= LOAD_W'(LOAD_MAX))
        else $error("load percent above full scale");

    a_cylon_one_led: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && mode_reg == MODE_CYLON |-> $onehot0(m_led_bits))
        else $error("more than one LED lit in sweep mode");

    a_bar_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && mode_reg == MODE_BARGRAPH |->
            (m_led_bits == 8'h00 || m_led_bits == 8'h80 || m_led_bits == 8'hC0 ||
             m_led_bits == 8'hE0 || m_led_bits == 8'hF8 || m_led_bits == 8'hFC ||
             m_led_bits == 8'hFE || m_led_bits == 8'hFF))
        else $error("bargraph pattern is not a left fill");

endmodule

bind load_meter_led_pattern_unit lmlp_checker u_lmlp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_led_bits     (m_led_bits),
    .m_load_percent (m_load_percent)
);

`default_nettype wire

FILE: test/tb_load_meter_led_pattern_unit.sv
`timescale 1ns / 1ps

module tb_load_meter_led_pattern_unit;
    import lmlp_pkg::*;

    typedef struct {
        logic [LED_W-1:0]  leds;
        logic [LOAD_W-1:0] load;
    } lamp_word_t;

    logic                   aclk;
    logic                   aresetn        = 1'b0;
    logic                   cfg_valid      = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index      = '0;
    logic [CFG_DATA_W-1:0]  cfg_data       = '0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic [IDLE_WIDTH-1:0]  s_idle_count   = '0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic [LED_W-1:0]       m_led_bits;
    logic [LOAD_W-1:0]      m_load_percent;

    // Register settings as the meter should currently see them.
    mode_t                  set_mode;
    logic [POLL_W-1:0]      set_poll;
    logic [EXPECT_W-1:0]    set_expected;
    logic [SCALE_W-1:0]     set_scale;

    // Meter state tracked alongside the block.
    logic [POLL_W-1:0]      tick_count;
    logic [IDLE_WIDTH-1:0]  idle_base;
    logic                   base_seeded;
    logic [LOAD_W-1:0]      load_now;
    logic [SWEEP_W-1:0]     sweep_acc;
    logic [RAND_W-1:0]      rand_acc;
    logic [LED_W-1:0]       rand_pattern;
    logic [LFSR_W-1:0]      lfsr_state;

    logic [IDLE_WIDTH-1:0]  idle_samples[$];
    lamp_word_t             lamp_words_due[$];

    logic [IDLE_WIDTH-1:0]  idle_acc;
    int                     shortfall;
    bit                     send_calm;
    bit                     recv_calm;
    int                     send_gap;
    int                     recv_gap;
    int                     mismatches;
    int                     samples_sent;
    int                     words_checked;
    int                     cfg_writes;
    int                     load_updates;
    int                     load_peak;
    int                     lfsr_steps;

    load_meter_led_pattern_unit u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_idle_count   (s_idle_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_led_bits     (m_led_bits),
        .m_load_percent (m_load_percent)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(99, 0);
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(3, 1);
        end
        if (r < 97) begin
            return $urandom_range(10, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    function automatic void store_setting(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_MODE:     set_mode = mode_t'(value[MODE_W-1:0]);
            CFG_POLL:     set_poll = value[POLL_W-1:0];
            CFG_EXPECTED: set_expected = value[EXPECT_W-1:0];
            CFG_SCALE:    set_scale = value[SCALE_W-1:0];
            default:      ;
        endcase
    endfunction

    // One display tick of the meter: load tracking, then the selected pattern.
    function automatic lamp_word_t advance_meter(input logic [IDLE_WIDTH-1:0] sample);
        lamp_word_t            word;
        logic [IDLE_WIDTH-1:0] delta;
        int                    limit;
        int                    level;
        int                    acc;
        int                    pos;
        int                    idx;
        word.leds = '0;
        if (!base_seeded) begin
            // The first tick after reset only records the baseline.
            idle_base   = sample;
            base_seeded = 1'b1;
        end else begin
            limit = (set_poll == 0) ? 1 : int'(set_poll);
            if (int'(tick_count) + 1 >= limit) begin
                tick_count = '0;
                delta = sample - idle_base;
                level = 0;
                if (delta < set_expected) begin
                    level = (int'(set_expected) - int'(delta)) * int'(set_scale);
                    if (level > LOAD_MAX) begin
                        level = LOAD_MAX;
                    end
                end
                load_now  = LOAD_W'(level);
                idle_base = sample;
                load_updates++;
                if (level > load_peak) begin
                    load_peak = level;
                end
            end else begin
                tick_count = tick_count + 1'b1;
            end

            case (set_mode)
                MODE_BARGRAPH: begin
                    idx = int'(load_now) / 3;
                    if (idx > 7) begin
                        idx = 7;
                    end
                    // Fill from the left; the fourth step jumps straight to five LEDs.
                    word.leds = ~(8'hFF >> ((idx < 4) ? idx : idx + 1));
                end
                MODE_CYLON: begin
                    acc = int'(sweep_acc) + 3 + (int'(load_now) * 97) / 100;
                    if (acc >= 1400) begin
                        acc = 0;
                    end
                    sweep_acc = SWEEP_W'(acc);
                    pos = acc / 100;
                    word.leds = 8'h80 >> ((pos <= 7) ? pos : 14 - pos);
                end
                MODE_RANDOM: begin
                    acc = int'(rand_acc) + 4 + (int'(load_now) * 96) / 100;
                    if (acc > 100) begin
                        acc = 0;
                        if (lfsr_state[0]) begin
                            lfsr_state = (lfsr_state >> 1) ^ 16'hB400;
                        end else begin
                            lfsr_state = lfsr_state >> 1;
                        end
                        rand_pattern = lfsr_state[7:0];
                        lfsr_steps++;
                    end
                    rand_acc  = RAND_W'(acc);
                    word.leds = rand_pattern;
                end
                default: word.leds = '0;
            endcase
        end
        word.load = load_now;
        return word;
    endfunction

    // Idle counter that advances by roughly expected_idle minus a drifting
    // shortfall per poll interval, so the load lands across its whole range.
    function automatic logic [IDLE_WIDTH-1:0] next_sample();
        int                    limit;
        int                    span;
        logic [IDLE_WIDTH-1:0] step;
        limit = (set_poll == 0) ? 1 : int'(set_poll);
        if ($urandom_range(99, 0) < 8) begin
            idle_acc = $urandom();
        end else begin
            if ($urandom_range(7, 0) == 0) begin
                shortfall = $urandom_range(110, 0) / ((set_scale == 0) ? 1 : int'(set_scale));
            end
            span = (int'(set_expected) > shortfall) ? int'(set_expected) - shortfall : 0;
            step = span / limit;
            if ($urandom_range(limit - 1, 0) < span % limit) begin
                step = step + 1'b1;
            end
            idle_acc = idle_acc + step;
        end
        return idle_acc;
    endfunction

    always @(posedge aclk) begin : sample_driver
        lamp_word_t word;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                word = advance_meter(s_idle_count);
                lamp_words_due.push_back(word);
                samples_sent++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (idle_samples.size() > 0) begin
                    s_valid      <= 1'b1;
                    s_idle_count <= idle_samples.pop_front();
                    send_gap = pick_gap(send_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : lamp_monitor
        lamp_word_t want;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (lamp_words_due.size() == 0) begin
                    $display("%0t: unexpected word leds=%h load=%0d", $time,
                             m_led_bits, m_load_percent);
                    mismatches++;
                end else begin
                    want = lamp_words_due.pop_front();
                    if (m_led_bits !== want.leds) begin
                        $display("%0t: led_bits expected %h actual %h", $time,
                                 want.leds, m_led_bits);
                        mismatches++;
                    end
                    if (m_load_percent !== want.load) begin
                        $display("%0t: load_percent expected %0d actual %0d", $time,
                                 want.load, m_load_percent);
                        mismatches++;
                    end
                    words_checked++;
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                if (m_valid && m_ready) begin
                    recv_gap = pick_gap(recv_calm);
                end
                m_ready <= (recv_gap == 0);
            end
        end
    end

    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (idle_samples.size() != 0 || s_valid || lamp_words_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        store_setting(idx, value);
        cfg_writes++;
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] mode, poll, idle_full, scale);
        wait_drained();
        repeat (3) @(negedge aclk);
        @(posedge aclk);
        write_reg(CFG_MODE, mode);
        write_reg(CFG_POLL, poll);
        write_reg(CFG_EXPECTED, idle_full);
        write_reg(CFG_SCALE, scale);
        // Indexes past the last register must leave everything untouched.
        write_reg(CFG_INDEX_W'(4 + $urandom_range(251, 0)), CFG_DATA_W'($urandom()));
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic push_samples(input int count);
        for (int i = 0; i < count; i++) begin
            idle_samples.push_back(next_sample());
        end
    endtask

    initial begin
        set_mode     = MODE_CYLON;
        set_poll     = 8'd25;
        set_expected = 16'd50;
        set_scale    = 4'd2;
        tick_count   = '0;
        idle_base    = '0;
        base_seeded  = 1'b0;
        load_now     = '0;
        sweep_acc    = '0;
        rand_acc     = '0;
        rand_pattern = '0;
        lfsr_state   = 16'h0001;
        idle_acc     = '0;
        shortfall    = 0;
        send_calm    = 1'b0;
        recv_calm    = 1'b0;
        mismatches   = 0;
        samples_sent = 0;
        words_checked = 0;
        cfg_writes   = 0;
        load_updates = 0;
        load_peak    = 0;
        lfsr_steps   = 0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Seeding tick, then sweep mode on the reset settings.
        idle_samples.push_back(32'hFFFF_FFF0);
        idle_samples.push_back(32'h0000_0000);
        idle_samples.push_back(32'hFFFF_FFFF);

        // Bargraph, recompute every tick; the lowered interval fires at once.
        configure(CFG_DATA_W'(MODE_BARGRAPH), 16'd1, 16'd50, 16'd15);
        idle_samples.push_back(32'hFFFF_FFFA);
        idle_samples.push_back(32'h0000_0004);
        idle_samples.push_back(32'h0000_0031);
        idle_samples.push_back(32'h0000_0062);
        idle_samples.push_back(32'h0000_0094);
        idle_samples.push_back(32'h0000_047C);

        // Random mode; the written values carry bits above each register width,
        // and the poll interval masks down to zero.
        configure(16'h0002 | 16'hFFF0, 16'hFF00, 16'hFFFF, 16'h00F1);
        idle_samples.push_back(32'h0000_047C);
        idle_samples.push_back(32'h0000_047C);
        idle_samples.push_back(32'h0001_047B);
        idle_samples.push_back(32'h0000_0000);
        idle_samples.push_back(32'h7FFF_FFFF);
        idle_samples.push_back(32'hFFFF_FFFF);

        // The unused mode blanks the LEDs while the load is still tracked.
        configure(16'hFFFF, 16'd1, 16'd60, 16'd2);
        push_samples(3);

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: configure(CFG_DATA_W'(MODE_BARGRAPH), 16'd1, 16'd40, 16'd3);
                1: configure(CFG_DATA_W'(MODE_CYLON), 16'd4, 16'hFFFF, 16'd15);
                2: configure(CFG_DATA_W'(MODE_RANDOM), 16'd2, 16'd200, 16'd1);
                3: configure(CFG_DATA_W'(MODE_RANDOM), 16'd1, 16'd30, 16'd4);
                4: configure(CFG_DATA_W'(MODE_CYLON), 16'd255, 16'd1000, 16'd7);
                5: configure(CFG_DATA_W'(MODE_BARGRAPH), 16'd3, 16'd0, 16'd15);
                6: configure(CFG_DATA_W'(MODE_OFF), 16'd5, 16'd60, 16'd2);
                7: configure(CFG_DATA_W'($urandom_range(2, 0)), 16'd3, 16'd80, 16'd0);
                default: configure(CFG_DATA_W'($urandom_range(3, 0)),
                                   CFG_DATA_W'($urandom_range(8, 1)),
                                   CFG_DATA_W'($urandom_range(300, 10)),
                                   CFG_DATA_W'($urandom_range(15, 1)));
            endcase
            send_calm = (ph % 4 == 1);
            recv_calm = (ph % 4 == 2);
            if (ph == 2) begin
                // Let the pipeline run dry in the middle of a stream.
                push_samples(26);
                wait_drained();
                push_samples(27);
            end else begin
                push_samples(53);
            end
        end

        wait_drained();
        repeat (6) @(posedge aclk);
        $display("Sent %0d idle samples through all four pattern modes, %0d register writes.",
                 samples_sent, cfg_writes);
        $display("Checked %0d words: %0d load updates, peak load %0d, %0d LFSR steps.",
                 words_checked, load_updates, load_peak, lfsr_steps);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
